>>> rtl/tsa_pkg.sv
// Shared types, constants and helpers for the thread slot allocator.
// No dependencies; used by every other file of the block.
`default_nettype none
package tsa_pkg;

    localparam int NUM_SLOTS = 8;
    localparam int NUM_CORES = 4;
    localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CORE_W    = (NUM_CORES > 1) ? $clog2(NUM_CORES) : 1;

    // request commands
    localparam logic [1:0] CMD_NEW    = 2'd0;
    localparam logic [1:0] CMD_RESUME = 2'd1;
    localparam logic [1:0] CMD_SUSP   = 2'd2;
    localparam logic [1:0] CMD_FREE   = 2'd3;

    // result status
    localparam logic [1:0] RS_OK         = 2'd0;
    localparam logic [1:0] RS_BUSY       = 2'd1;
    localparam logic [1:0] RS_RESUME_ERR = 2'd2;
    localparam logic [1:0] RS_BAD        = 2'd3;

    // slot states
    localparam logic [1:0] SS_FREE   = 2'd0;
    localparam logic [1:0] SS_ACTIVE = 2'd1;
    localparam logic [1:0] SS_SUSP   = 2'd2;

    typedef logic [SLOT_W-1:0] t_slot;

    // controller -> datapath
    typedef struct packed {
        logic load;    // capture request fields
        logic scan;    // register table summaries and lookups
        logic commit;  // apply update, load result register
    } t_dp_ctl;

    // datapath -> controller
    typedef struct packed {
        logic out_free;  // result register can take a new result this cycle
    } t_dp_sts;

    // low three bits of a slot number
    function automatic logic [2:0] slot_to_out(input t_slot s);
        logic [7:0] w;
        w = 8'(s);
        return w[2:0];
    endfunction

endpackage
`default_nettype wire

>>> rtl/tsa_ctrl.sv
// Request sequencer: idle, table scan, execute.
// Depends on tsa_pkg; drives tsa_datapath through t_dp_ctl.
`default_nettype none
module tsa_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_stall,
    input  wire tsa_pkg::t_dp_sts i_sts,
    output tsa_pkg::t_dp_ctl      o_ctl
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_EXEC = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state      = r_state;
        o_ctl.load   = 1'b0;
        o_ctl.scan   = 1'b0;
        o_ctl.commit = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_ctl.load = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                o_ctl.scan = 1'b1;
                n_state    = S_EXEC;
            end
            S_EXEC: begin
                if (i_sts.out_free) begin
                    o_ctl.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_stall = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

`ifndef SYNTH
    // a taken request always passes through scan and then reaches execute
    a_load_to_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctl.load |=> ##1 (r_state == S_EXEC))
        else $error("request did not reach execute");
`endif

endmodule
`default_nettype wire

>>> rtl/tsa_datapath.sv
// Slot table, per-core current slot, decision logic and result register.
// Depends on tsa_pkg; sequenced by tsa_ctrl.
`default_nettype none
module tsa_datapath (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire tsa_pkg::t_dp_ctl i_ctl,
    output tsa_pkg::t_dp_sts      o_sts,
    input  wire logic [1:0]       i_cmd,
    input  wire logic [1:0]       i_core_id,
    input  wire logic [7:0]       i_slot_id,
    input  wire logic [31:0]      i_client_id,
    input  wire logic             i_exit_on_irq,
    input  wire logic             i_copy_args,
    output logic                  o_valid,
    input  wire logic             i_stall,
    output logic [1:0]            o_status,
    output logic [2:0]            o_slot_out,
    output logic                  o_copy_args_now
);

    localparam logic [1:0] UPD_NONE   = 2'd0;
    localparam logic [1:0] UPD_NEW    = 2'd1;
    localparam logic [1:0] UPD_RESUME = 2'd2;
    localparam logic [1:0] UPD_RETIRE = 2'd3;  // suspend or free

    // slot table
    logic [1:0]                        r_slot_state [tsa_pkg::NUM_SLOTS];
    logic [tsa_pkg::NUM_SLOTS-1:0]     r_slot_pre;
    logic [tsa_pkg::NUM_SLOTS-1:0]     r_slot_copy;
    logic [31:0]                       r_slot_client [tsa_pkg::NUM_SLOTS];
    logic [tsa_pkg::NUM_CORES-1:0]     r_core_has;
    tsa_pkg::t_slot                    r_core_slot [tsa_pkg::NUM_CORES];

    // captured request
    logic [1:0]  r_cmd;
    logic [1:0]  r_core;
    logic [7:0]  r_sid;
    logic [31:0] r_client;
    logic        r_irq;
    logic        r_cpy;

    // scan results
    logic           r_any_act;
    logic           r_any_pre;
    logic           r_free_found;
    tsa_pkg::t_slot r_free_idx;
    logic           r_core_ok;
    logic           r_has;
    tsa_pkg::t_slot r_cur;
    logic           r_cur_act;
    logic           r_sid_ok;
    logic           r_sel_susp;
    logic           r_sel_pre;
    logic           r_sel_copy;
    logic           r_sel_match;

    // result register
    logic        r_out_valid;
    logic [1:0]  r_out_status;
    logic [2:0]  r_out_slot;
    logic        r_out_copy;

    // combinational
    logic [tsa_pkg::NUM_SLOTS-1:0] w_active;
    logic [tsa_pkg::NUM_SLOTS-1:0] w_susp_pre;
    logic                          w_free_found;
    tsa_pkg::t_slot                w_free_idx;
    logic [3:0]                    w_core_ext;
    logic [tsa_pkg::CORE_W-1:0]    w_core_idx;
    tsa_pkg::t_slot                w_sid_idx;
    tsa_pkg::t_slot                w_cur;
    logic [1:0]                    w_status;
    tsa_pkg::t_slot                w_slot;
    logic                          w_copy_now;
    logic [1:0]                    w_upd;

    assign w_core_ext = 4'(r_core);
    assign w_core_idx = w_core_ext[tsa_pkg::CORE_W-1:0];
    assign w_sid_idx  = r_sid[tsa_pkg::SLOT_W-1:0];
    assign w_cur      = r_core_slot[w_core_idx];

    always_comb begin
        w_free_found = 1'b0;
        w_free_idx   = '0;
        for (int i = 0; i < tsa_pkg::NUM_SLOTS; i++) begin
            w_active[i]   = (r_slot_state[i] == tsa_pkg::SS_ACTIVE);
            w_susp_pre[i] = (r_slot_state[i] == tsa_pkg::SS_SUSP) && r_slot_pre[i];
        end
        // lowest free slot
        for (int i = tsa_pkg::NUM_SLOTS - 1; i >= 0; i--) begin
            if (r_slot_state[i] == tsa_pkg::SS_FREE) begin
                w_free_found = 1'b1;
                w_free_idx   = tsa_pkg::SLOT_W'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd    <= i_cmd;
            r_core   <= i_core_id;
            r_sid    <= i_slot_id;
            r_client <= i_client_id;
            r_irq    <= i_exit_on_irq;
            r_cpy    <= i_copy_args;
        end
        if (i_ctl.scan) begin
            r_any_act    <= |w_active;
            r_any_pre    <= |w_susp_pre;
            r_free_found <= w_free_found;
            r_free_idx   <= w_free_idx;
            r_core_ok    <= (w_core_ext < 4'(tsa_pkg::NUM_CORES));
            r_has        <= r_core_has[w_core_idx];
            r_cur        <= w_cur;
            r_cur_act    <= (r_slot_state[w_cur] == tsa_pkg::SS_ACTIVE);
            r_sid_ok     <= (r_sid < 8'(tsa_pkg::NUM_SLOTS));
            r_sel_susp   <= (r_slot_state[w_sid_idx] == tsa_pkg::SS_SUSP);
            r_sel_pre    <= r_slot_pre[w_sid_idx];
            r_sel_copy   <= r_slot_copy[w_sid_idx];
            r_sel_match  <= (r_slot_client[w_sid_idx] == r_client);
        end
    end

    // decision
    always_comb begin
        w_status   = tsa_pkg::RS_BAD;
        w_slot     = '0;
        w_copy_now = 1'b0;
        w_upd      = UPD_NONE;
        if (r_core_ok) begin
            unique case (r_cmd)
                tsa_pkg::CMD_NEW: begin
                    if (r_has) begin
                        w_status = tsa_pkg::RS_BAD;
                    end else if (!r_any_act && !r_any_pre && r_free_found) begin
                        w_status = tsa_pkg::RS_OK;
                        w_slot   = r_free_idx;
                        w_upd    = UPD_NEW;
                    end else begin
                        w_status = tsa_pkg::RS_BUSY;
                    end
                end
                tsa_pkg::CMD_RESUME: begin
                    if (r_has) begin
                        w_status = tsa_pkg::RS_BAD;
                    end else if (r_any_act) begin
                        w_status = tsa_pkg::RS_BUSY;
                    end else if (r_sid_ok && r_sel_susp && r_sel_match) begin
                        if (r_any_pre && !r_sel_pre) begin
                            w_status = tsa_pkg::RS_BUSY;
                        end else begin
                            w_status   = tsa_pkg::RS_OK;
                            w_slot     = w_sid_idx;
                            w_copy_now = r_sel_copy;
                            w_upd      = UPD_RESUME;
                        end
                    end else begin
                        w_status = tsa_pkg::RS_RESUME_ERR;
                    end
                end
                tsa_pkg::CMD_SUSP, tsa_pkg::CMD_FREE: begin
                    if (r_has && r_cur_act) begin
                        w_status = tsa_pkg::RS_OK;
                        w_slot   = r_cur;
                        w_upd    = UPD_RETIRE;
                    end
                end
                default: begin
                    w_status = tsa_pkg::RS_BAD;
                end
            endcase
        end
    end

    // table update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < tsa_pkg::NUM_SLOTS; i++) begin
                r_slot_state[i] <= tsa_pkg::SS_FREE;
            end
            for (int c = 0; c < tsa_pkg::NUM_CORES; c++) begin
                r_core_slot[c] <= '0;
            end
            r_slot_pre  <= '0;
            r_slot_copy <= '0;
            r_core_has  <= '0;
        end else if (i_ctl.commit) begin
            unique case (w_upd)
                UPD_NEW: begin
                    r_slot_state[w_slot]    <= tsa_pkg::SS_ACTIVE;
                    r_slot_pre[w_slot]      <= 1'b0;
                    r_slot_copy[w_slot]     <= 1'b0;
                    r_core_has[w_core_idx]  <= 1'b1;
                    r_core_slot[w_core_idx] <= w_slot;
                end
                UPD_RESUME: begin
                    r_slot_state[w_slot]    <= tsa_pkg::SS_ACTIVE;
                    r_slot_pre[w_slot]      <= 1'b0;
                    r_slot_copy[w_slot]     <= 1'b0;
                    r_core_has[w_core_idx]  <= 1'b1;
                    r_core_slot[w_core_idx] <= w_slot;
                end
                UPD_RETIRE: begin
                    r_core_has[w_core_idx] <= 1'b0;
                    if (r_cmd == tsa_pkg::CMD_SUSP) begin
                        r_slot_state[w_slot] <= tsa_pkg::SS_SUSP;
                        r_slot_pre[w_slot]   <= r_slot_pre[w_slot] | r_irq;
                        r_slot_copy[w_slot]  <= r_slot_copy[w_slot] | r_cpy;
                    end else begin
                        r_slot_state[w_slot] <= tsa_pkg::SS_FREE;
                        r_slot_pre[w_slot]   <= 1'b0;
                        r_slot_copy[w_slot]  <= 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // client ids: no reset, only read for suspended slots
    always_ff @(posedge i_clk) begin
        if (i_ctl.commit && (w_upd == UPD_NEW)) begin
            r_slot_client[w_slot] <= r_client;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctl.commit) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.commit) begin
            r_out_status <= w_status;
            r_out_slot   <= tsa_pkg::slot_to_out(w_slot);
            r_out_copy   <= w_copy_now;
        end
    end

    assign o_sts.out_free  = !r_out_valid || !i_stall;
    assign o_valid         = r_out_valid;
    assign o_status        = r_out_status;
    assign o_slot_out      = r_out_slot;
    assign o_copy_args_now = r_out_copy;

`ifndef SYNTH
    a_one_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_active) <= 1)
        else $error("more than one active slot");

    a_owner_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_core_has) == $countones(w_active))
        else $error("core ownership out of step with active slots");

    a_commit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.commit |-> o_sts.out_free)
        else $error("result overwritten before it was taken");

    a_copy_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_copy) |-> (r_out_status == tsa_pkg::RS_OK))
        else $error("copy flag on a failed request");
`endif

endmodule
`default_nettype wire

>>> rtl/thread_slot_allocator.sv
// Thread slot allocator top level: sequencer plus slot table datapath.
// A request is captured in IDLE, its table scan is registered in SCAN, and its
// result is loaded into the result register in EXEC; a previous result still
// stalled holds EXEC back. No new request is taken before the last leaves EXEC.
// Reset (i_rst_n low, synchronous): all slots free with marks cleared, no core
// holds a slot, no result pending. Client ids are not reset.
// Depends on tsa_pkg, tsa_ctrl and tsa_datapath.
`default_nettype none
module thread_slot_allocator (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // request channel
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_cmd,
    input  wire logic [1:0]  i_core_id,
    input  wire logic [7:0]  i_slot_id,
    input  wire logic [31:0] i_client_id,
    input  wire logic        i_exit_on_irq,
    input  wire logic        i_copy_args,
    // result channel
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [1:0]       o_status,
    output logic [2:0]       o_slot_out,
    output logic             o_copy_args_now
);

    // Sequencing: IDLE takes a request and captures its fields; SCAN registers
    // the table summaries (any active, any preempted, lowest free) and the
    // per-request lookups; EXEC decides, updates the table and loads the
    // result register once that register is free. The result register lets
    // the next request be taken while a result waits downstream.
    tsa_pkg::t_dp_ctl w_ctl;
    tsa_pkg::t_dp_sts w_sts;

    tsa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (w_sts),
        .o_ctl   (w_ctl)
    );

    tsa_datapath u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctl           (w_ctl),
        .o_sts           (w_sts),
        .i_cmd           (i_cmd),
        .i_core_id       (i_core_id),
        .i_slot_id       (i_slot_id),
        .i_client_id     (i_client_id),
        .i_exit_on_irq   (i_exit_on_irq),
        .i_copy_args     (i_copy_args),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_status        (o_status),
        .o_slot_out      (o_slot_out),
        .o_copy_args_now (o_copy_args_now)
    );

endmodule
`default_nettype wire
